// File: hdl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; used by sfr_window and stream_find_replace_unit.
package sfr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CNT_W      = 15;
	localparam int LIMIT_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT       = 3'd4;

	localparam int USER_BYTE_VALID  = 0;
	localparam int USER_STRING_DONE = 1;

	typedef logic [7:0][7:0] byte8_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} win_cmd_t;

endpackage

// File: hdl/sfr_window.sv
// Match window: holds the bytes that still form a prefix of the pattern.
// Depends on sfr_pkg for the command struct and byte vector type.
module sfr_window #(
	parameter int MAX_PATTERN = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sfr_pkg::win_cmd_t                 cmd,
	input  logic [7:0]                        push_byte,
	input  sfr_pkg::byte8_t                   pattern,
	output logic [$clog2(MAX_PATTERN+1)-1:0]  fill,
	output logic [7:0]                        head,
	output logic                              match
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]        win_q [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q[fill_q[IDX_W-1:0]] <= push_byte;
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.clear) begin
			fill_q <= '0;
		end else if (cmd.push) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (cmd.pop) begin
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((FILL_W'(i) < fill_q) && (win_q[i] != pattern[i])) begin
				match = 1'b0;
			end
		end
	end

	assign fill = fill_q;
	assign head = win_q[0];

endmodule

// File: hdl/stream_find_replace_unit.sv
// Stream find-and-replace-all: top level with sequencer, config and output stage.
// Depends on sfr_pkg and sfr_window.
//
// Replaces every leftmost, non-overlapping occurrence of the configured pattern in
// a byte stream with the replacement, one input beat per byte, s_axis_tlast on the
// final byte of a string. One byte is in flight at a time. A beat is accepted, then
// passes through the window recheck steps and emitted bytes (mismatch rollback, each
// replacement byte, each flushed byte and the terminator), then a closing step; a
// stalled output beat holds the sequencer until it is taken. A byte copied with a
// zero pattern length skips the window. The window sequencer compares the whole
// window and shifts it by one position per cycle while the output is not stalled.
// Output beats carry tlast on the last beat caused by an input beat; a beat that
// causes nothing emits nothing.
module stream_find_replace_unit #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [7:0] in_byte
	input  logic                            s_axis_tlast,   // end_of_input
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]                      m_axis_tuser,   // [0] byte_valid, [1] string_done
	output logic                            m_axis_tlast,   // run_last
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int RL_W   = $clog2(MAX_REPLACEMENT + 1);
	localparam int RI_W   = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_REP,
		S_TAIL,
		S_DONE
	} state_t;

	state_t                         state_q, state_d;
	sfr_pkg::byte8_t                pattern_q, replacement_q;
	logic [3:0]                     pat_len_q, rep_len_q;
	logic [sfr_pkg::LIMIT_W-1:0]    limit_q;
	logic [sfr_pkg::CNT_W-1:0]      cnt_q, cap;
	logic [RI_W-1:0]                rep_idx_q, rep_idx_d;
	logic                           last_q;

	logic                           pend_v_q, pend_bv_q, pend_done_q;
	logic [7:0]                     pend_byte_q;
	logic                           out_v_q, out_bv_q, out_done_q, out_last_q;
	logic [7:0]                     out_byte_q;

	logic [FILL_W-1:0]              plen, fill;
	logic [RL_W-1:0]                rlen;
	logic [7:0]                     head;
	logic                           match, room, out_free, stall, fin, cnt_clr;
	logic                           gen, gen_bv, gen_done;
	logic [7:0]                     gen_byte;
	logic                           cfg_wr;
	state_t                         after;
	sfr_pkg::win_cmd_t              win_cmd;

	sfr_window #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (win_cmd),
		.push_byte (s_axis_tdata),
		.pattern   (pattern_q),
		.fill      (fill),
		.head      (head),
		.match     (match)
	);

	assign cfg_ready     = 1'b1;
	assign cfg_wr        = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == S_IDLE);

	assign plen = (pat_len_q > 4'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN) : FILL_W'(pat_len_q);
	assign rlen = (rep_len_q > 4'(MAX_REPLACEMENT)) ? RL_W'(MAX_REPLACEMENT) : RL_W'(rep_len_q);

	always_comb begin
		if (limit_q == '0) begin
			cap = '0;
		end else if (limit_q > 16'd32768) begin
			cap = '1;
		end else begin
			cap = sfr_pkg::CNT_W'(limit_q - 16'd1);
		end
	end

	assign room     = (cnt_q < cap);
	assign out_free = !out_v_q || m_axis_tready;
	assign stall    = pend_v_q && !out_free;
	assign after    = last_q ? S_TAIL : S_DONE;

	always_comb begin
		state_d       = state_q;
		rep_idx_d     = rep_idx_q;
		gen           = 1'b0;
		gen_byte      = head;
		gen_bv        = 1'b1;
		gen_done      = 1'b0;
		cnt_clr       = 1'b0;
		fin           = 1'b0;
		win_cmd       = '0;
		win_cmd.clear = cfg_wr && (cfg_index == sfr_pkg::CFG_PATTERN_LENGTH);
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					if (plen == '0) begin
						gen      = room;
						gen_byte = s_axis_tdata;
						state_d  = s_axis_tlast ? S_TAIL : S_DONE;
					end else begin
						win_cmd.push = 1'b1;
						state_d      = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (!stall) begin
					if (fill == '0) begin
						state_d = after;
					end else if (match) begin
						if (fill == plen) begin
							win_cmd.clear = 1'b1;
							rep_idx_d     = '0;
							state_d       = (rlen == '0) ? after : S_REP;
						end else begin
							state_d = after;
						end
					end else begin
						gen         = room;
						win_cmd.pop = 1'b1;
					end
				end
			end
			S_REP: begin
				if (!stall) begin
					gen       = room;
					gen_byte  = replacement_q[rep_idx_q];
					rep_idx_d = rep_idx_q + RI_W'(1);
					if (RL_W'(rep_idx_q) + RL_W'(1) == rlen) begin
						state_d = after;
					end
				end
			end
			S_TAIL: begin
				if (!stall) begin
					if (fill != '0) begin
						gen         = room;
						win_cmd.pop = 1'b1;
					end else begin
						gen      = 1'b1;
						gen_bv   = 1'b0;
						gen_done = 1'b1;
						gen_byte = '0;
						cnt_clr  = 1'b1;
						state_d  = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pattern_q     <= '0;
			pat_len_q     <= '0;
			replacement_q <= '0;
			rep_len_q     <= '0;
			limit_q       <= 16'd32768;
			cnt_q         <= '0;
			rep_idx_q     <= '0;
			last_q        <= 1'b0;
			pend_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			rep_idx_q <= rep_idx_d;

			if (cfg_wr) begin
				case (cfg_index)
					sfr_pkg::CFG_PATTERN_BYTES:      pattern_q     <= cfg_data;
					sfr_pkg::CFG_PATTERN_LENGTH:     pat_len_q     <= cfg_data[3:0];
					sfr_pkg::CFG_REPLACEMENT_BYTES:  replacement_q <= cfg_data;
					sfr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_q     <= cfg_data[3:0];
					sfr_pkg::CFG_OUTPUT_LIMIT:       limit_q       <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				last_q <= s_axis_tlast;
			end

			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (gen && gen_bv) begin
				cnt_q <= cnt_q + sfr_pkg::CNT_W'(1);
			end

			if ((gen && pend_v_q) || fin) begin
				out_v_q     <= 1'b1;
				out_byte_q  <= pend_byte_q;
				out_bv_q    <= pend_bv_q;
				out_done_q  <= pend_done_q;
				out_last_q  <= fin;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			if (gen) begin
				pend_v_q    <= 1'b1;
				pend_byte_q <= gen_byte;
				pend_bv_q   <= gen_bv;
				pend_done_q <= gen_done;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser[sfr_pkg::USER_BYTE_VALID]  = out_bv_q;
	assign m_axis_tuser[sfr_pkg::USER_STRING_DONE] = out_done_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_v_q)
		else $error("pending result held while accepting input");

	a_window_below_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && plen != '0) |-> (fill < plen))
		else $error("window holds a full pattern between beats");

	a_rep_window_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REP) |-> (fill == '0))
		else $error("window not emptied before replacement");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[sfr_pkg::USER_STRING_DONE])
			|-> (m_axis_tlast && !m_axis_tuser[sfr_pkg::USER_BYTE_VALID]))
		else $error("terminator beat not last or carries a byte");

endmodule
